// ===== rtl/irc_lt_pkg.sv =====
// shared constants, types and keyword table of the irc line tokenizer
`default_nettype none

package irc_lt_pkg;

    localparam int MAX_COMMAND_LEN = 7;
    localparam int CMD_LEN_W       = $clog2(MAX_COMMAND_LEN + 1);
    localparam int PARAM_COUNT_MAX = 255;

    localparam int NUM_KEYWORDS = 13;
    localparam int KW_CHARS     = 7;
    localparam int KW_LEN_W     = $clog2(KW_CHARS + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;

    // keywords right-aligned, first character in the highest used byte
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        "PASS", "NICK", "USER", "JOIN", "PART", "QUIT", "PRIVMSG",
        "NOTICE", "KICK", "MODE", "TOPIC", "INVITE", "PING"
    };
    localparam logic [KW_LEN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd7,
        3'd6, 3'd4, 3'd4, 3'd5, 3'd6, 3'd4
    };

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_PREFIX = 3'd1,
        PH_CMD    = 3'd2,
        PH_PSTART = 3'd3,
        PH_PARAM  = 3'd4,
        PH_TRAIL  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        CLS_PREFIX_COLON = 3'd0,
        CLS_PREFIX       = 3'd1,
        CLS_COMMAND      = 3'd2,
        CLS_SPACE        = 3'd3,
        CLS_PARAM        = 3'd4,
        CLS_TRAIL_COLON  = 3'd5,
        CLS_TRAIL        = 3'd6
    } t_class;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        t_class     byte_class;
        logic [7:0] param_index;
        logic       message_end;
        logic       line_valid;
        logic [3:0] command_code;
        logic [7:0] param_count;
    } t_result;

    // up to two results written to the output queue per accepted request
    typedef struct packed {
        logic [1:0] count;
        t_result    e0;
        t_result    e1;
    } t_push;

    // character at position pos of keyword idx, zero past its end
    function automatic logic [7:0] kw_char(input int idx,
                                           input logic [CMD_LEN_W-1:0] pos);
        logic [7:0] c;
        int         base;
        c = '0;
        base = 0;
        if (int'(pos) < int'(KW_LEN[idx])) begin
            base = 8 * (int'(KW_LEN[idx]) - 1 - int'(pos));
            c = KW_TEXT[idx][base +: 8];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/irc_lt_parse.sv =====
// line parser: holds one byte back, classifies kept bytes, reports line status
`default_nettype none

module irc_lt_parse (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_data,
    input  wire logic               i_last,
    output irc_lt_pkg::t_push       o_push
);

    typedef struct packed {
        irc_lt_pkg::t_phase                          phase;
        logic [irc_lt_pkg::NUM_KEYWORDS-1:0]         cands;
        logic [irc_lt_pkg::CMD_LEN_W-1:0]            cmd_len;
        logic [7:0]                                  ptotal;
        logic                                        pbroken;
    } t_pstate;

    typedef struct packed {
        t_pstate             st;
        logic [7:0]          b;
        irc_lt_pkg::t_class  cls;
        logic [7:0]          idx;
    } t_step;

    localparam t_pstate LINE_CLEAR = '{
        phase:   irc_lt_pkg::PH_START,
        cands:   '1,
        cmd_len: '0,
        ptotal:  '0,
        pbroken: 1'b0
    };

    localparam irc_lt_pkg::t_result NO_RESULT = '{
        out_byte:     '0,
        byte_present: 1'b0,
        byte_class:   irc_lt_pkg::CLS_PREFIX_COLON,
        param_index:  '0,
        message_end:  1'b0,
        line_valid:   1'b0,
        command_code: '0,
        param_count:  '0
    };

    function automatic t_pstate f_cmd_byte(input t_pstate s, input logic [7:0] b);
        t_pstate o;
        logic    keep;
        o = s;
        for (int i = 0; i < irc_lt_pkg::NUM_KEYWORDS; i++) begin
            keep = (s.cmd_len < irc_lt_pkg::CMD_LEN_W'(irc_lt_pkg::KW_LEN[i]))
                && (irc_lt_pkg::kw_char(i, s.cmd_len) == b);
            if (!keep) begin
                o.cands[i] = 1'b0;
            end
        end
        if (s.cmd_len < irc_lt_pkg::CMD_LEN_W'(irc_lt_pkg::MAX_COMMAND_LEN)) begin
            o.cmd_len = s.cmd_len + 1'b1;
        end
        return o;
    endfunction

    function automatic logic [7:0] f_cur_index(input logic [7:0] pt);
        return (pt != 8'd0) ? pt - 8'd1 : 8'd0;
    endfunction

    function automatic t_step f_classify(input t_pstate s, input logic [7:0] b);
        t_step o;
        o.st  = s;
        o.b   = b;
        o.cls = irc_lt_pkg::CLS_PREFIX_COLON;
        o.idx = '0;
        case (s.phase)
            irc_lt_pkg::PH_PREFIX: begin
                if (b == irc_lt_pkg::CH_SP) begin
                    o.cls        = irc_lt_pkg::CLS_SPACE;
                    o.st.phase   = irc_lt_pkg::PH_CMD;
                    o.st.pbroken = 1'b0;
                end else begin
                    o.cls = irc_lt_pkg::CLS_PREFIX;
                end
            end
            irc_lt_pkg::PH_CMD: begin
                if (b == irc_lt_pkg::CH_SP) begin
                    o.cls      = irc_lt_pkg::CLS_SPACE;
                    o.st.phase = irc_lt_pkg::PH_PSTART;
                end else begin
                    o.cls = irc_lt_pkg::CLS_COMMAND;
                    o.st  = f_cmd_byte(s, b);
                end
            end
            irc_lt_pkg::PH_PSTART: begin
                if (s.ptotal < 8'(irc_lt_pkg::PARAM_COUNT_MAX)) begin
                    o.st.ptotal = s.ptotal + 8'd1;
                end
                o.idx = f_cur_index(o.st.ptotal);
                if (b == irc_lt_pkg::CH_SP) begin
                    o.cls = irc_lt_pkg::CLS_SPACE;
                end else if (b == irc_lt_pkg::CH_COLON) begin
                    o.cls      = irc_lt_pkg::CLS_TRAIL_COLON;
                    o.st.phase = irc_lt_pkg::PH_TRAIL;
                end else begin
                    o.cls      = irc_lt_pkg::CLS_PARAM;
                    o.st.phase = irc_lt_pkg::PH_PARAM;
                end
            end
            irc_lt_pkg::PH_PARAM: begin
                if (b == irc_lt_pkg::CH_SP) begin
                    o.cls      = irc_lt_pkg::CLS_SPACE;
                    o.st.phase = irc_lt_pkg::PH_PSTART;
                end else begin
                    o.cls = irc_lt_pkg::CLS_PARAM;
                    o.idx = f_cur_index(s.ptotal);
                end
            end
            irc_lt_pkg::PH_TRAIL: begin
                o.cls = irc_lt_pkg::CLS_TRAIL;
                o.idx = f_cur_index(s.ptotal);
            end
            default: begin
                // line start, unused phase codes included
                if (b == irc_lt_pkg::CH_COLON) begin
                    o.cls        = irc_lt_pkg::CLS_PREFIX_COLON;
                    o.st.phase   = irc_lt_pkg::PH_PREFIX;
                    o.st.pbroken = 1'b1;
                end else if (b == irc_lt_pkg::CH_SP) begin
                    o.cls      = irc_lt_pkg::CLS_SPACE;
                    o.st.phase = irc_lt_pkg::PH_PSTART;
                end else begin
                    o.cls       = irc_lt_pkg::CLS_COMMAND;
                    o.st        = f_cmd_byte(s, b);
                    o.st.phase  = irc_lt_pkg::PH_CMD;
                end
            end
        endcase
        return o;
    endfunction

    function automatic irc_lt_pkg::t_result f_to_result(input t_step c);
        irc_lt_pkg::t_result r;
        r              = NO_RESULT;
        r.out_byte     = c.b;
        r.byte_present = 1'b1;
        r.byte_class   = c.cls;
        r.param_index  = c.idx;
        return r;
    endfunction

    t_pstate             r_st, n_st;
    logic [7:0]          r_held_byte, n_held_byte;
    logic                r_held_full, n_held_full;

    t_step               c_held, c_new;
    t_pstate             s_mid, s_end;
    logic                keep_held, keep_new;
    logic [3:0]          end_code;
    irc_lt_pkg::t_result end_res;

    always_comb begin
        keep_held = r_held_full;
        keep_new  = 1'b1;
        // crlf pair drops both bytes, a lone cr or lf drops the final byte
        if (i_data == irc_lt_pkg::CH_LF && r_held_full
                && r_held_byte == irc_lt_pkg::CH_CR) begin
            keep_held = 1'b0;
            keep_new  = 1'b0;
        end else if (i_data == irc_lt_pkg::CH_CR || i_data == irc_lt_pkg::CH_LF) begin
            keep_new = 1'b0;
        end

        c_held = f_classify(r_st, r_held_byte);
        s_mid  = keep_held ? c_held.st : r_st;
        c_new  = f_classify(s_mid, i_data);
        s_end  = keep_new ? c_new.st : s_mid;

        end_code = '0;
        for (int i = irc_lt_pkg::NUM_KEYWORDS - 1; i >= 0; i--) begin
            if (s_end.cands[i]
                    && irc_lt_pkg::CMD_LEN_W'(irc_lt_pkg::KW_LEN[i]) == s_end.cmd_len) begin
                end_code = 4'(i + 1);
            end
        end

        end_res              = keep_new ? f_to_result(c_new) : NO_RESULT;
        end_res.message_end  = 1'b1;
        end_res.line_valid   = (end_code != 4'd0) && !s_end.pbroken;
        end_res.command_code = end_code;
        end_res.param_count  = s_end.ptotal;

        n_st        = r_st;
        n_held_byte = r_held_byte;
        n_held_full = r_held_full;
        o_push      = '{count: 2'd0, e0: NO_RESULT, e1: NO_RESULT};

        if (i_accept) begin
            if (!i_last) begin
                n_held_byte = i_data;
                n_held_full = 1'b1;
                if (r_held_full) begin
                    o_push.count = 2'd1;
                    o_push.e0    = f_to_result(c_held);
                    n_st         = c_held.st;
                end
            end else begin
                if (keep_held) begin
                    o_push.count = 2'd2;
                    o_push.e0    = f_to_result(c_held);
                    o_push.e1    = end_res;
                end else begin
                    o_push.count = 2'd1;
                    o_push.e0    = end_res;
                end
                n_st        = LINE_CLEAR;
                n_held_byte = '0;
                n_held_full = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= LINE_CLEAR;
            r_held_byte <= '0;
            r_held_full <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_held_byte <= n_held_byte;
            r_held_full <= n_held_full;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/irc_lt_outq.sv =====
// result queue: takes up to two results a cycle, hands out one a cycle while i_ready is high
`default_nettype none

module irc_lt_outq (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire irc_lt_pkg::t_push      i_push,
    output logic                        o_room,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output irc_lt_pkg::t_result         o_head
);

    irc_lt_pkg::t_result                    r_mem [irc_lt_pkg::OQ_DEPTH];
    logic [irc_lt_pkg::OQ_PTR_W-1:0]        r_wp, n_wp;
    logic [irc_lt_pkg::OQ_PTR_W-1:0]        r_rp, n_rp;
    logic [irc_lt_pkg::OQ_CNT_W-1:0]        r_count, n_count;
    logic                                   pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    // room for the two results a line end can produce
    assign o_room  = (r_count <= irc_lt_pkg::OQ_CNT_W'(irc_lt_pkg::OQ_DEPTH - 2));
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp    = r_wp + irc_lt_pkg::OQ_PTR_W'(i_push.count);
        n_rp    = r_rp + irc_lt_pkg::OQ_PTR_W'(pop);
        n_count = r_count + irc_lt_pkg::OQ_CNT_W'(i_push.count)
                - irc_lt_pkg::OQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.e0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wp + irc_lt_pkg::OQ_PTR_W'(1)] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/irc_line_tokenizer_unit.sv =====
// top level of the irc line tokenizer
//
//  channel  dir  tdata                                   tuser                 tlast
//  s_axis   in   data_byte[7:0]                          -                     line_last
//  m_axis   out  out_byte[7:0] param_index[15:8]         byte_present[0]       message_end
//                line_valid[16] command_code[20:17]      byte_class[3:1]
//                param_count[28:21], zero above
//
// one request per cycle while s_axis_tready is high; the parser keeps one byte back, so a
// byte's result appears once the next byte of the line arrives or the line ends.
// a final byte can release two results, which leave one at a time from a
// four-entry result queue; s_axis_tready drops while fewer than two slots are free.
// m_axis stalls fill the queue and never touch parser state.
// reset (i_rst_n low, synchronous) empties the queue and returns to line start.
`default_nettype none

module irc_line_tokenizer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // out_byte, param_index, line_valid,
                                             // command_code, param_count
    output logic [3:0]       m_axis_tuser,   // byte_present, byte_class
    output logic             m_axis_tlast
);

    irc_lt_pkg::t_push   push;
    irc_lt_pkg::t_result head;
    logic                accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    irc_lt_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push)
    );

    irc_lt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (head)
    );

    assign m_axis_tdata = {3'd0, head.param_count, head.command_code, head.line_valid,
                           head.param_index, head.out_byte};
    assign m_axis_tuser = {head.byte_class, head.byte_present};
    assign m_axis_tlast = head.message_end;

endmodule

`default_nettype wire

// ===== rtl/irc_lt_checker.sv =====
// port-level checks of the irc line tokenizer, bound to the top level
`default_nettype none

module irc_lt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [3:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ s_axis_tlast;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result request right after reset");

    // a result without a byte only closes a line and carries a zero byte
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0]
            |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0 && m_axis_tuser[3:1] == 3'd0)
        else $error("status-only result malformed");

    a_mid_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[28:16] == 13'd0)
        else $error("line status shown before line end");

    a_valid_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata[16] |-> m_axis_tdata[20:17] != 4'd0)
        else $error("valid line without command code");

endmodule

bind irc_line_tokenizer_unit irc_lt_checker u_irc_lt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
